>>> hdl/char_lcd_4bit_interface_core_macros.svh
// Assertion macros used by the checker file of the LCD interface core.
`ifndef CHAR_LCD_4BIT_INTERFACE_CORE_MACROS_SVH
`define CHAR_LCD_4BIT_INTERFACE_CORE_MACROS_SVH

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define CL4_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cl4 check failed");

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define CL4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cl4 check failed");

// Checked through reset as well: consequent must hold in the next cycle.
`define CL4_ASSERT_RESET(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cl4 check failed");

`endif

>>> hdl/cl4_pkg.sv
package cl4_pkg;

  // Init wait lengths in delay units.
  localparam logic [7:0] POWER_ON_UNITS    = 8'd15;
  localparam logic [7:0] SECOND_WAIT_UNITS = 8'd5;

  // Reset values of the configuration registers.
  localparam logic [15:0] UNIT_TICKS_RESET     = 16'd1000;
  localparam logic [1:0]  FUNCTION_FLAGS_RESET = 2'd2;
  localparam logic [1:0]  ENTRY_FLAGS_RESET    = 2'd2;
  localparam logic [2:0]  DISPLAY_FLAGS_RESET  = 3'd7;

  // Display command bytes and init nibbles.
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
  localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h08;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h04;
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

  // Init steps with a meaning of their own.
  localparam logic [3:0] STEP_FOUR_BIT = 4'd3;
  localparam logic [3:0] STEP_CMD_LO   = 4'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_INIT  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_UNIT_TICKS     = 2'd0,
    CFG_FUNCTION_FLAGS = 2'd1,
    CFG_ENTRY_FLAGS    = 2'd2,
    CFG_DISPLAY_FLAGS  = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_WAIT     = 4'd1,
    PH_N_SETUP  = 4'd2,
    PH_N_E      = 4'd3,
    PH_N_L      = 4'd4,
    PH_RD_SETUP = 4'd5,
    PH_RD_HI_E  = 4'd6,
    PH_RD_HI_L  = 4'd7,
    PH_RD_LO_E  = 4'd8,
    PH_RD_LO_L  = 4'd9,
    PH_WR_SETUP = 4'd10,
    PH_WR_HI_E  = 4'd11,
    PH_WR_HI_L  = 4'd12,
    PH_WR_LO_E  = 4'd13,
    PH_WR_LO_L  = 4'd14
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       req_rs;
    logic [7:0] req_data;
    logic [3:0] bus_in;
  } in_item_t;

  typedef struct packed {
    logic       pin_rs;
    logic       pin_rw;
    logic       pin_e;
    logic [3:0] bus_out;
    logic       bus_drive;
    logic       ready_res;
    logic       init_done;
    logic [7:0] last_status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] unit_ticks;
    logic [1:0]  function_flags;
    logic [1:0]  entry_flags;
    logic [2:0]  display_flags;
  } cfg_regs_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] tick_count;
    logic [7:0]  unit_count;
    logic [7:0]  byte_hold;
    logic        rs_hold;
    logic [3:0]  init_step;
    logic [7:0]  status_hold;
    logic        init_flag;
  } seq_state_t;

endpackage

>>> hdl/cl4_seq.sv
// Next-state and pin logic of the sequencer for one tick.
module cl4_seq import cl4_pkg::*; #(
  parameter logic [7:0] POWER_ON_WAIT = POWER_ON_UNITS,
  parameter logic [7:0] SECOND_WAIT   = SECOND_WAIT_UNITS
) (
  input  cfg_regs_t  cfg,
  input  seq_state_t state,
  input  in_item_t   item,
  output seq_state_t state_nxt,
  output out_item_t  result
);

  // Length of a wait phase in units, chosen by the init step.
  function automatic logic [7:0] wait_len(input logic [3:0] step);
    logic [7:0] len;
    case (step)
      4'd0:    len = POWER_ON_WAIT;
      4'd1:    len = SECOND_WAIT;
      default: len = 8'd1;
    endcase
    return len;
  endfunction

  // Move on to the next init step after a nibble or a command is sent.
  function automatic seq_state_t init_continue(input seq_state_t s, input cfg_regs_t c);
    seq_state_t r;
    logic [3:0] stp;
    r = s;
    stp = s.init_step + 4'd1;
    r.init_step = stp;
    r.rs_hold = 1'b0;
    r.tick_count = '0;
    r.unit_count = '0;
    case (stp)
      4'd1, 4'd2: r.phase = PH_WAIT;
      4'd3:       r.phase = PH_N_SETUP;
      4'd4: begin
        r.byte_hold = CMD_FUNCTION_SET | {4'b0, c.function_flags, 2'b0};
        r.phase = PH_RD_SETUP;
      end
      4'd5: begin
        r.byte_hold = CMD_DISPLAY_CTRL;
        r.phase = PH_RD_SETUP;
      end
      4'd6: begin
        r.byte_hold = CMD_CLEAR;
        r.phase = PH_RD_SETUP;
      end
      4'd7: begin
        r.byte_hold = CMD_ENTRY_MODE | {6'b0, c.entry_flags};
        r.phase = PH_RD_SETUP;
      end
      4'd8: begin
        r.byte_hold = CMD_DISPLAY_CTRL | {5'b0, c.display_flags};
        r.phase = PH_RD_SETUP;
      end
      default: begin
        r.init_flag = 1'b1;
        r.init_step = '0;
        r.phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // Transition at the end of a phase; every branch restarts the counters.
  function automatic seq_state_t phase_done(input seq_state_t s, input logic [3:0] bus,
                                            input cfg_regs_t c);
    seq_state_t r;
    r = s;
    r.tick_count = '0;
    r.unit_count = '0;
    case (s.phase)
      PH_WAIT:     r.phase = PH_N_SETUP;
      PH_N_SETUP:  r.phase = PH_N_E;
      PH_N_E:      r.phase = PH_N_L;
      PH_N_L:      r = init_continue(s, c);
      PH_RD_SETUP: r.phase = PH_RD_HI_E;
      PH_RD_HI_E: begin
        r.status_hold = {bus, s.status_hold[3:0]};
        r.phase = PH_RD_HI_L;
      end
      PH_RD_HI_L:  r.phase = PH_RD_LO_E;
      PH_RD_LO_E: begin
        r.status_hold = {s.status_hold[7:4], bus};
        r.phase = PH_RD_LO_L;
      end
      PH_RD_LO_L:  r.phase = s.status_hold[7] ? PH_RD_SETUP : PH_WR_SETUP;
      PH_WR_SETUP: r.phase = PH_WR_HI_E;
      PH_WR_HI_E:  r.phase = PH_WR_HI_L;
      PH_WR_HI_L:  r.phase = PH_WR_LO_E;
      PH_WR_LO_E:  r.phase = PH_WR_LO_L;
      PH_WR_LO_L: begin
        if (s.init_step >= STEP_CMD_LO) begin
          r = init_continue(s, c);
        end else begin
          r.phase = PH_IDLE;
        end
      end
      default:     r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

  always_comb begin
    seq_state_t  s;
    logic [15:0] ut;
    logic [15:0] tc_inc;
    logic [7:0]  uc_inc;
    logic [7:0]  len;
    logic [3:0]  init_nib;
    out_item_t   o;

    s = state;
    o = '0;

    // Start a request only while idle; requests at other times are dropped.
    if (s.phase == PH_IDLE) begin
      if (item.opcode == OP_WRITE) begin
        s.rs_hold = item.req_rs;
        s.byte_hold = item.req_data;
        s.init_step = '0;
        s.phase = PH_RD_SETUP;
        s.tick_count = '0;
        s.unit_count = '0;
      end else if (item.opcode == OP_INIT) begin
        s.init_step = '0;
        s.init_flag = 1'b0;
        s.phase = PH_WAIT;
        s.tick_count = '0;
        s.unit_count = '0;
      end
    end

    // Pin levels for this tick follow the phase after any start.
    init_nib = (s.init_step == STEP_FOUR_BIT) ? NIB_FOUR_BIT : NIB_WAKE;
    case (s.phase)
      PH_N_E: begin
        o.pin_e = 1'b1;
        o.bus_drive = 1'b1;
        o.bus_out = init_nib;
      end
      PH_N_L: begin
        o.bus_drive = 1'b1;
        o.bus_out = init_nib;
      end
      PH_RD_SETUP, PH_RD_HI_L, PH_RD_LO_L: o.pin_rw = 1'b1;
      PH_RD_HI_E, PH_RD_LO_E: begin
        o.pin_rw = 1'b1;
        o.pin_e = 1'b1;
      end
      PH_WR_SETUP: o.pin_rs = s.rs_hold;
      PH_WR_HI_E: begin
        o.pin_rs = s.rs_hold;
        o.pin_e = 1'b1;
        o.bus_drive = 1'b1;
        o.bus_out = s.byte_hold[7:4];
      end
      PH_WR_HI_L: begin
        o.pin_rs = s.rs_hold;
        o.bus_drive = 1'b1;
        o.bus_out = s.byte_hold[7:4];
      end
      PH_WR_LO_E: begin
        o.pin_rs = s.rs_hold;
        o.pin_e = 1'b1;
        o.bus_drive = 1'b1;
        o.bus_out = s.byte_hold[3:0];
      end
      PH_WR_LO_L: begin
        o.pin_rs = s.rs_hold;
        o.bus_drive = 1'b1;
        o.bus_out = s.byte_hold[3:0];
      end
      default: ;
    endcase

    // Advance the tick and unit counters; a zero unit length counts as one.
    ut = (cfg.unit_ticks == '0) ? 16'd1 : cfg.unit_ticks;
    len = (s.phase == PH_WAIT) ? wait_len(s.init_step) : 8'd1;
    tc_inc = s.tick_count + 16'd1;
    uc_inc = s.unit_count + 8'd1;
    if (s.phase != PH_IDLE) begin
      if (tc_inc >= ut) begin
        s.tick_count = '0;
        s.unit_count = uc_inc;
        if (uc_inc >= len) begin
          s = phase_done(s, item.bus_in, cfg);
        end
      end else begin
        s.tick_count = tc_inc;
      end
    end

    // Flags report the state after this tick.
    o.ready_res = (s.phase == PH_IDLE);
    o.init_done = s.init_flag;
    o.last_status = s.status_hold;

    state_nxt = s;
    result = o;
  end

endmodule

>>> hdl/char_lcd_4bit_interface_core.sv
// Character LCD interface core for a 4-bit character display bus. Each input item is one
// timing tick, optionally carrying a byte write or an init request; each item yields exactly
// one result item with the pin levels for that tick and the status flags after it. The core
// takes one item per clock cycle and its result is available in the cycle after acceptance,
// held in a single output register; the input stalls only while that register holds a
// result that the output side is stalling. Writes poll the busy flag before sending the two
// nibbles, and every pin phase of a read or write lasts unit_ticks ticks (zero acts as one);
// init waits last POWER_ON_WAIT, SECOND_WAIT, then 1 unit. Configuration is written through
// the cfg port (index 0 unit_ticks, 1 function_flags, 2 entry_flags, 3 display_flags),
// which is always ready.
module char_lcd_4bit_interface_core import cl4_pkg::*; #(
  parameter logic [7:0] POWER_ON_WAIT = POWER_ON_UNITS,
  parameter logic [7:0] SECOND_WAIT   = SECOND_WAIT_UNITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t  cfg_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  out_item_t  result;
  out_item_t  out_data_r;
  logic       out_valid_r;
  logic       in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ticks <= UNIT_TICKS_RESET;
      cfg_r.function_flags <= FUNCTION_FLAGS_RESET;
      cfg_r.entry_flags <= ENTRY_FLAGS_RESET;
      cfg_r.display_flags <= DISPLAY_FLAGS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UNIT_TICKS:     cfg_r.unit_ticks <= cfg_data;
        CFG_FUNCTION_FLAGS: cfg_r.function_flags <= cfg_data[1:0];
        CFG_ENTRY_FLAGS:    cfg_r.entry_flags <= cfg_data[1:0];
        CFG_DISPLAY_FLAGS:  cfg_r.display_flags <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // One tick of sequencer logic.
  cl4_seq #(
    .POWER_ON_WAIT (POWER_ON_WAIT),
    .SECOND_WAIT   (SECOND_WAIT)
  ) u_seq (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (in_data),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Sequencer state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, default: '0};
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Output register: loaded on accept, emptied when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result;
    end
  end

endmodule

>>> hdl/cl4_checker.sv
`include "char_lcd_4bit_interface_core_macros.svh"

// Port-level checks of the LCD interface core.
module cl4_checker import cl4_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data
);

  // A stalled result stays in place.
  `CL4_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // The input is held off only while a stalled result is waiting.
  `CL4_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall)

  // The core never drives the bus during a read phase.
  `CL4_ASSERT_NOW(a_rw_no_drive, clk, rst_n, out_valid && out_data.pin_rw, !out_data.bus_drive)

  // An enable pulse is always followed by a hold phase, so the core cannot be idle.
  `CL4_ASSERT_NOW(a_e_busy, clk, rst_n, out_valid && out_data.pin_e, !out_data.ready_res)

  // The core leaves reset with no pending result.
  `CL4_ASSERT_RESET(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind char_lcd_4bit_interface_core cl4_checker u_cl4_checker (.*);
